@@ src/smd_pkg.sv @@
// Shared types, constants and table functions for the segment magnitude/direction core.
`timescale 1ns / 1ps
package smd_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int DIR_WIDTH       = 16;
  localparam int CORDIC_STEPS    = 60;
  localparam int ACC_W           = 64;
  localparam int ACC_FRAC        = 62;
  // The normalized magnitude sits in [2^(NORM_MSB-1), 2^NORM_MSB).
  localparam int NORM_MSB        = 60;
  // The angle keeps ACC_FRAC fraction bits; the result keeps 13, so drop 49.
  localparam int DIR_LSB         = 49;

  typedef struct packed {
    logic valid;
    logic xneg;
    logic yneg;
    logic zero;
  } smd_ctl_t;

  // Restoring division, used only while building the arctangent table.
  function automatic logic [ACC_W-1:0] udiv64(input logic [ACC_W-1:0] n,
                                              input logic [ACC_W-1:0] d);
    logic [ACC_W-1:0] q;
    logic [ACC_W:0]   r;
    q = '0;
    r = '0;
    for (int b = ACC_W - 1; b >= 0; b--) begin
      r = {r[ACC_W-1:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in 2^-62 units from the Taylor series, for i >= 1.
  function automatic logic [ACC_W-1:0] atan_pow2(input int i);
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] term;
    int               e;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      e = i * (2 * k + 1);
      if (e <= ACC_FRAC) begin
        term = udiv64(ACC_W'(1) << (ACC_FRAC - e), ACC_W'(2 * k + 1));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  // atan(1/3) in 2^-62 units.
  function automatic logic [ACC_W-1:0] atan_third();
    logic [ACC_W-1:0] p;
    logic [ACC_W-1:0] sum;
    logic [ACC_W-1:0] term;
    p   = (ACC_W'(1) << ACC_FRAC) / ACC_W'(3);
    sum = '0;
    for (int k = 0; k < ACC_W; k++) begin
      if (p != '0) begin
        term = udiv64(p, ACC_W'(2 * k + 1));
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        p = p / ACC_W'(9);
      end
    end
    return sum;
  endfunction

  // Rotation angle of CORDIC step i; step 0 uses pi/4 = atan(1/2) + atan(1/3).
  function automatic logic [ACC_W-1:0] atan_entry(input int i);
    logic [ACC_W-1:0] v;
    if (i == 0) begin
      v = atan_pow2(1) + atan_third();
    end else begin
      v = atan_pow2(i);
    end
    return v;
  endfunction

endpackage

@@ src/segment_magnitude_and_direction_core.sv @@
// Top level of the segment magnitude and direction core.
`timescale 1ns / 1ps
// Usage notes.
// Each input request carries one line segment as four signed fixed point
// coordinates with 8 fraction bits. The core forms the difference vector and
// returns one result request per segment: its Euclidean length in the same
// format, rounded to the nearest step, and its direction atan2(dy, dx) in
// radians with 13 fraction bits over -pi..pi. A zero vector gives 0 and 0.
// Requests move on a stream handshake: a request is taken at a rising edge
// where tvalid and tready are both high. Results leave in input order.
// From the accepting edge to out_tvalid a segment passes six front stages
// (difference, magnitude, squares, three normalization stages), a chain of 60
// CORDIC cells in which the first COORD_WIDTH+1 cells also settle one bit of
// the integer square root each, one fix-up stage and the output register.
// Throughput is one segment per cycle unless stalled; the cells move as one.
// When the receiver stalls, the output register holds its result and the pipe
// keeps moving as long as its last stage is empty, so bubbles close up before
// in_tready falls. A synchronous active low reset clears all valid flags; the
// core keeps no other state and needs no configuration.
module segment_magnitude_and_direction_core #(
  parameter int COORD_WIDTH = smd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst_n,
  input  logic                                                    in_tvalid,
  output logic                                                    in_tready,
  // start_x, start_y, end_x, end_y from the lowest bit up, zero padded.
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]                      in_tdata,
  output logic                                                    out_tvalid,
  input  logic                                                    out_tready,
  // length, direction from the lowest bit up, zero padded.
  output logic [((COORD_WIDTH+1+smd_pkg::DIR_WIDTH+7)/8)*8-1:0]   out_tdata
);
  import smd_pkg::*;

  localparam int ROOT_BITS  = COORD_WIDTH + 1;
  localparam int RAD_W      = 2 * ROOT_BITS;
  localparam int REM_W      = ROOT_BITS + 1;
  localparam int OUT_DATA_W = ((ROOT_BITS + DIR_WIDTH + 7) / 8) * 8;

  logic                         en;
  logic [COORD_WIDTH-1:0]       start_x, start_y, end_x, end_y;
  logic [ROOT_BITS-1:0]         length;
  logic signed [DIR_WIDTH-1:0]  direction;

  // Signals that run along the cell chain; index 0 feeds the first cell.
  smd_ctl_t             ctl_c  [0:CORDIC_STEPS];
  logic [ACC_W-1:0]     x_c    [0:CORDIC_STEPS];
  logic [ACC_W-1:0]     y_c    [0:CORDIC_STEPS];
  logic [ACC_W-1:0]     z_c    [0:CORDIC_STEPS];
  logic [RAD_W-1:0]     rad_c  [0:CORDIC_STEPS];
  logic [REM_W-1:0]     rem_c  [0:CORDIC_STEPS];
  logic [ROOT_BITS-1:0] root_c [0:CORDIC_STEPS];

  assign start_x = in_tdata[0*COORD_WIDTH +: COORD_WIDTH];
  assign start_y = in_tdata[1*COORD_WIDTH +: COORD_WIDTH];
  assign end_x   = in_tdata[2*COORD_WIDTH +: COORD_WIDTH];
  assign end_y   = in_tdata[3*COORD_WIDTH +: COORD_WIDTH];

  // The whole pipe advances together; a request enters whenever it advances.
  assign in_tready = en;

  smd_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .ctl_o    (ctl_c[0]),
    .x_o      (x_c[0]),
    .y_o      (y_c[0]),
    .rad_o    (rad_c[0])
  );

  // The angle accumulator and the square root both start from zero.
  assign z_c[0]    = '0;
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  generate
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      smd_cell #(
        .COORD_WIDTH (COORD_WIDTH),
        .STEP        (i)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .ctl_i  (ctl_c[i]),
        .x_i    (x_c[i]),
        .y_i    (y_c[i]),
        .z_i    (z_c[i]),
        .rad_i  (rad_c[i]),
        .rem_i  (rem_c[i]),
        .root_i (root_c[i]),
        .ctl_o  (ctl_c[i+1]),
        .x_o    (x_c[i+1]),
        .y_o    (y_c[i+1]),
        .z_o    (z_c[i+1]),
        .rad_o  (rad_c[i+1]),
        .rem_o  (rem_c[i+1]),
        .root_o (root_c[i+1])
      );
    end
  endgenerate

  // The back end owns the output register and decides when the pipe moves.
  smd_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (ctl_c[CORDIC_STEPS]),
    .z_i         (z_c[CORDIC_STEPS]),
    .rem_i       (rem_c[CORDIC_STEPS]),
    .root_i      (root_c[CORDIC_STEPS]),
    .out_ready   (out_tready),
    .en_o        (en),
    .out_valid   (out_tvalid),
    .length_o    (length),
    .direction_o (direction)
  );

  assign out_tdata = OUT_DATA_W'({direction, length});

endmodule

@@ src/smd_front.sv @@
// Front pipeline: difference vector, magnitudes, squares and normalization.
`timescale 1ns / 1ps
module smd_front #(
  parameter int COORD_WIDTH = smd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [COORD_WIDTH-1:0]              start_x,
  input  logic [COORD_WIDTH-1:0]              start_y,
  input  logic [COORD_WIDTH-1:0]              end_x,
  input  logic [COORD_WIDTH-1:0]              end_y,
  output smd_pkg::smd_ctl_t                   ctl_o,
  output logic [smd_pkg::ACC_W-1:0]           x_o,
  output logic [smd_pkg::ACC_W-1:0]           y_o,
  output logic [2*(COORD_WIDTH+1)-1:0]        rad_o
);
  import smd_pkg::*;

  localparam int ROOT_BITS = COORD_WIDTH + 1;
  localparam int RAD_W     = 2 * ROOT_BITS;

  function automatic logic need_shift(input logic [ACC_W-1:0] m, input int k);
    return (m >> (NORM_MSB - k)) == '0;
  endfunction

  function automatic logic [ACC_W-1:0] shl_if(input logic [ACC_W-1:0] v,
                                              input logic c, input int k);
    return c ? (v << k) : v;
  endfunction

  // Stage 1: difference vector.
  logic                 v1_r;
  logic [ROOT_BITS-1:0] dx_r, dy_r;
  // Stage 2: absolute values and signs.
  smd_ctl_t             ctl2_r;
  logic [ROOT_BITS-1:0] a_r, b_r;
  // Stage 3: squares and the starting vector.
  smd_ctl_t             ctl3_r;
  logic [RAD_W-1:0]     a2_r, b2_r;
  logic [ACC_W-1:0]     x3_r, y3_r, m3_r;
  // Stages 4 to 6: normalization, two binary shift steps each.
  smd_ctl_t             ctl4_r, ctl5_r, ctl6_r;
  logic [RAD_W-1:0]     rad4_r, rad5_r, rad6_r;
  logic [ACC_W-1:0]     x4_r, y4_r, m4_r, x5_r, y5_r, m5_r, x6_r, y6_r;

  logic [ROOT_BITS-1:0] dx_nxt, dy_nxt, a_nxt, b_nxt;
  logic [ACC_W-1:0]     y3_nxt, m3_nxt;
  logic [ACC_W-1:0]     m4a, x4a, y4a, m4_nxt, x4_nxt, y4_nxt;
  logic [ACC_W-1:0]     m5a, x5a, y5a, m5_nxt, x5_nxt, y5_nxt;
  logic [ACC_W-1:0]     m6a, x6a, y6a, x6_nxt, y6_nxt;
  logic                 c32, c16, c8, c4, c2, c1;

  always_comb begin
    dx_nxt = {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
    dy_nxt = {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};
    a_nxt  = dx_r[ROOT_BITS-1] ? (~dx_r) + ROOT_BITS'(1) : dx_r;
    b_nxt  = dy_r[ROOT_BITS-1] ? (~dy_r) + ROOT_BITS'(1) : dy_r;
    y3_nxt = ctl2_r.yneg ? (~ACC_W'(b_r)) + ACC_W'(1) : ACC_W'(b_r);
    m3_nxt = ACC_W'((a_r > b_r) ? a_r : b_r);

    c32    = need_shift(m3_r, 32);
    m4a    = shl_if(m3_r, c32, 32);
    x4a    = shl_if(x3_r, c32, 32);
    y4a    = shl_if(y3_r, c32, 32);
    c16    = need_shift(m4a, 16);
    m4_nxt = shl_if(m4a, c16, 16);
    x4_nxt = shl_if(x4a, c16, 16);
    y4_nxt = shl_if(y4a, c16, 16);

    c8     = need_shift(m4_r, 8);
    m5a    = shl_if(m4_r, c8, 8);
    x5a    = shl_if(x4_r, c8, 8);
    y5a    = shl_if(y4_r, c8, 8);
    c4     = need_shift(m5a, 4);
    m5_nxt = shl_if(m5a, c4, 4);
    x5_nxt = shl_if(x5a, c4, 4);
    y5_nxt = shl_if(y5a, c4, 4);

    c2     = need_shift(m5_r, 2);
    m6a    = shl_if(m5_r, c2, 2);
    x6a    = shl_if(x5_r, c2, 2);
    y6a    = shl_if(y5_r, c2, 2);
    c1     = need_shift(m6a, 1);
    x6_nxt = shl_if(x6a, c1, 1);
    y6_nxt = shl_if(y6a, c1, 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
      ctl5_r <= '0;
      ctl6_r <= '0;
    end else if (en) begin
      v1_r   <= in_valid;
      ctl2_r <= '{valid: v1_r, xneg: dx_r[ROOT_BITS-1], yneg: dy_r[ROOT_BITS-1],
                  zero: 1'b0};
      ctl3_r <= '{valid: ctl2_r.valid, xneg: ctl2_r.xneg, yneg: ctl2_r.yneg,
                  zero: (a_r == '0) && (b_r == '0)};
      ctl4_r <= ctl3_r;
      ctl5_r <= ctl4_r;
      ctl6_r <= ctl5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      a2_r   <= RAD_W'(a_r) * RAD_W'(a_r);
      b2_r   <= RAD_W'(b_r) * RAD_W'(b_r);
      x3_r   <= ACC_W'(a_r);
      y3_r   <= y3_nxt;
      m3_r   <= m3_nxt;
      rad4_r <= a2_r + b2_r;
      x4_r   <= x4_nxt;
      y4_r   <= y4_nxt;
      m4_r   <= m4_nxt;
      rad5_r <= rad4_r;
      x5_r   <= x5_nxt;
      y5_r   <= y5_nxt;
      m5_r   <= m5_nxt;
      rad6_r <= rad5_r;
      x6_r   <= x6_nxt;
      y6_r   <= y6_nxt;
    end
  end

  assign ctl_o = ctl6_r;
  assign x_o   = x6_r;
  assign y_o   = y6_r;
  assign rad_o = rad6_r;

endmodule

@@ src/smd_cell.sv @@
// One cell of the chain: a CORDIC vectoring step plus one square root digit.
`timescale 1ns / 1ps
module smd_cell #(
  parameter int COORD_WIDTH = smd_pkg::COORD_WIDTH_DEF,
  parameter int STEP        = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  smd_pkg::smd_ctl_t             ctl_i,
  input  logic [smd_pkg::ACC_W-1:0]     x_i,
  input  logic [smd_pkg::ACC_W-1:0]     y_i,
  input  logic [smd_pkg::ACC_W-1:0]     z_i,
  input  logic [2*(COORD_WIDTH+1)-1:0]  rad_i,
  input  logic [COORD_WIDTH+1:0]        rem_i,
  input  logic [COORD_WIDTH:0]          root_i,
  output smd_pkg::smd_ctl_t             ctl_o,
  output logic [smd_pkg::ACC_W-1:0]     x_o,
  output logic [smd_pkg::ACC_W-1:0]     y_o,
  output logic [smd_pkg::ACC_W-1:0]     z_o,
  output logic [2*(COORD_WIDTH+1)-1:0]  rad_o,
  output logic [COORD_WIDTH+1:0]        rem_o,
  output logic [COORD_WIDTH:0]          root_o
);
  import smd_pkg::*;

  localparam int ROOT_BITS = COORD_WIDTH + 1;
  localparam int RAD_W     = 2 * ROOT_BITS;
  localparam int REM_W     = ROOT_BITS + 1;
  localparam logic [ACC_W-1:0] ATAN = atan_entry(STEP);

  smd_ctl_t             ctl_r;
  logic [ACC_W-1:0]     x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, xs, ys;
  logic [RAD_W-1:0]     rad_r, rad_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;

  // Rotate toward the positive x axis, steering by the sign of y.
  always_comb begin
    xs = x_i >> STEP;
    ys = $signed(y_i) >>> STEP;
    if (!y_i[ACC_W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  // The first cells each settle one root bit; the rest carry the result along.
  // The trial value is four times the partial root plus one.
  generate
    if (STEP < ROOT_BITS) begin : g_root
      logic [REM_W+1:0] rem_sh, trial;
      always_comb begin
        rem_sh  = {rem_i, rad_i[RAD_W-1 -: 2]};
        trial   = {1'b0, root_i, 2'b01};
        rad_nxt = {rad_i[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_nxt  = REM_W'(rem_sh - trial);
          root_nxt = {root_i[ROOT_BITS-2:0], 1'b1};
        end else begin
          rem_nxt  = REM_W'(rem_sh);
          root_nxt = {root_i[ROOT_BITS-2:0], 1'b0};
        end
      end
    end else begin : g_pass
      always_comb begin
        rad_nxt  = rad_i;
        rem_nxt  = rem_i;
        root_nxt = root_i;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

@@ src/smd_back.sv @@
// Back end: quadrant fix-up, rounding of both results and the output register.
`timescale 1ns / 1ps
module smd_back #(
  parameter int COORD_WIDTH = smd_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smd_pkg::smd_ctl_t                   ctl_i,
  input  logic [smd_pkg::ACC_W-1:0]           z_i,
  input  logic [COORD_WIDTH+1:0]              rem_i,
  input  logic [COORD_WIDTH:0]                root_i,
  input  logic                                out_ready,
  output logic                                en_o,
  output logic                                out_valid,
  output logic [COORD_WIDTH:0]                length_o,
  output logic signed [smd_pkg::DIR_WIDTH-1:0] direction_o
);
  import smd_pkg::*;

  localparam int ROOT_BITS = COORD_WIDTH + 1;
  localparam int MAG_TOP_W = ACC_W - DIR_LSB + 1;
  localparam logic [ACC_W-1:0] ATAN0 = atan_entry(0);
  localparam logic [ACC_W-1:0] PI62  = ATAN0 << 2;

  smd_ctl_t                     ctl_r;
  logic                         neg_r, neg_nxt;
  logic [MAG_TOP_W-1:0]         mag_top_r;
  logic [ACC_W-1:0]             mag_nxt;
  logic [ROOT_BITS-1:0]         len_r, len_nxt;
  logic                         out_valid_r, out_load;
  logic [ROOT_BITS-1:0]         length_r;
  logic signed [DIR_WIDTH-1:0]  direction_r, dir_nxt;
  logic [MAG_TOP_W:0]           q_sum;
  logic [MAG_TOP_W-1:0]         q;

  always_comb begin
    if (ctl_i.xneg) begin
      neg_nxt = ctl_i.yneg;
      mag_nxt = ctl_i.yneg ? PI62 + z_i : PI62 - z_i;
    end else begin
      neg_nxt = z_i[ACC_W-1];
      mag_nxt = neg_nxt ? (~z_i) + ACC_W'(1) : z_i;
    end
    // Round the root up when the remainder exceeds it.
    len_nxt = root_i + ROOT_BITS'(rem_i > {1'b0, root_i});

    q_sum   = {1'b0, mag_top_r} + (MAG_TOP_W + 1)'(1);
    q       = q_sum[MAG_TOP_W:1];
    if (ctl_r.zero) begin
      dir_nxt = '0;
    end else if (neg_r) begin
      dir_nxt = DIR_WIDTH'((~q) + MAG_TOP_W'(1));
    end else begin
      dir_nxt = DIR_WIDTH'(q);
    end
  end

  // The output register loads when it is empty or being drained; the rest of
  // the pipe also moves when its last stage holds no request.
  assign out_load = !out_valid_r || out_ready;
  assign en_o     = out_load || !ctl_r.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_o) begin
        ctl_r <= ctl_i;
      end
      if (out_load) begin
        out_valid_r <= ctl_r.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_o) begin
      neg_r     <= neg_nxt;
      mag_top_r <= mag_nxt[ACC_W-1:DIR_LSB-1];
      len_r     <= len_nxt;
    end
    if (out_load) begin
      length_r    <= len_r;
      direction_r <= dir_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign length_o    = length_r;
  assign direction_o = direction_r;

endmodule
